// File: hw/rtl/pbme_pkg.sv
`default_nettype none

package pbme_pkg;

  localparam int TAG_W = 31;
  localparam int REQ_W = 3;
  localparam int STATUS_W = 2;

  // request codes on the input channel, code 7 is unused
  typedef enum logic [REQ_W-1:0] {
    REQ_ADD     = 3'd0,
    REQ_OPERAND = 3'd1,
    REQ_AND     = 3'd2,
    REQ_OR      = 3'd3,
    REQ_NOT     = 3'd4,
    REQ_FINISH  = 3'd5,
    REQ_CLEAR   = 3'd6
  } req_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 2'd0,
    ST_MISSING    = 2'd1,
    ST_NOT_SINGLE = 2'd2,
    ST_OVERFLOW   = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    SOP_NONE,
    SOP_PUSH,
    SOP_AND,
    SOP_OR,
    SOP_NOT,
    SOP_FINISH
  } stk_op_t;

  typedef struct packed {
    stk_op_t op;
    logic    bit_val;
  } stk_cmd_t;

  typedef struct packed {
    logic    full;
    logic    verdict;
    status_t status;
  } stk_stat_t;

endpackage

`default_nettype wire

// File: hw/rtl/pbme_ram.sv
`default_nettype none

module pbme_ram #(
  parameter int WIDTH = 31,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/pbme_stack.sv
`default_nettype none

module pbme_stack #(
  parameter int STACK_DEPTH = 32
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire pbme_pkg::stk_cmd_t  cmd,
  output pbme_pkg::stk_stat_t      stat
);

  import pbme_pkg::*;

  localparam int CW = $clog2(STACK_DEPTH + 1);

  // top of stack lives in bit 0, push shifts up, pop shifts down
  logic [STACK_DEPTH-1:0] bits_r, bits_nxt;
  logic [CW-1:0]          count_r, count_nxt;
  status_t                err_r, err_nxt;
  status_t                fin_status;

  always_comb begin
    fin_status = err_r;
    if (err_r == ST_OK && count_r != CW'(1)) begin
      fin_status = ST_NOT_SINGLE;
    end
    stat.full    = (count_r == CW'(STACK_DEPTH));
    stat.status  = fin_status;
    stat.verdict = (fin_status == ST_OK) ? bits_r[0] : 1'b0;
  end

  always_comb begin
    bits_nxt  = bits_r;
    count_nxt = count_r;
    err_nxt   = err_r;
    case (cmd.op)
      SOP_PUSH: begin
        if (count_r == CW'(STACK_DEPTH)) begin
          if (err_r == ST_OK) err_nxt = ST_OVERFLOW;
        end else begin
          bits_nxt    = bits_r << 1;
          bits_nxt[0] = cmd.bit_val;
          count_nxt   = count_r + CW'(1);
        end
      end
      SOP_AND, SOP_OR: begin
        if (count_r < CW'(2)) begin
          if (err_r == ST_OK) err_nxt = ST_MISSING;
        end else begin
          bits_nxt    = bits_r >> 1;
          bits_nxt[0] = (cmd.op == SOP_AND) ? (bits_r[0] & bits_r[1])
                                            : (bits_r[0] | bits_r[1]);
          count_nxt   = count_r - CW'(1);
        end
      end
      SOP_NOT: begin
        if (count_r == '0) begin
          if (err_r == ST_OK) err_nxt = ST_MISSING;
        end else begin
          bits_nxt[0] = ~bits_r[0];
        end
      end
      SOP_FINISH: begin
        count_nxt = '0;
        err_nxt   = ST_OK;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    bits_r <= bits_nxt;
    if (!rst_n) begin
      count_r <= '0;
      err_r   <= ST_OK;
    end else begin
      count_r <= count_nxt;
      err_r   <= err_nxt;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/pbme_scan.sv
`default_nettype none

module pbme_scan #(
  parameter int LIST_DEPTH = 64,
  parameter int AW         = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1,
  parameter int CW         = $clog2(LIST_DEPTH + 1)
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  input  wire logic [pbme_pkg::TAG_W-1:0] tag,
  input  wire logic [CW-1:0]              tag_count,
  output logic                            rd_en,
  output logic      [AW-1:0]              rd_addr,
  input  wire logic [pbme_pkg::TAG_W-1:0] rd_data,
  output logic                            busy,
  output logic                            done,
  output logic                            hit
);

  import pbme_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_SCAN
  } state_t;

  state_t            state_r;
  logic [TAG_W-1:0]  tag_r;
  logic [CW-1:0]     idx_r;
  logic              dvld_r;
  logic              dlast_r;
  logic              done_r;
  logic              hit_r;
  logic              match;
  logic              finish;

  // one list entry compared per cycle, read data arrives the cycle after its address
  always_comb begin
    match   = dvld_r && (rd_data == tag_r);
    finish  = dvld_r && (match || dlast_r);
    rd_en   = (state_r == S_SCAN) && !finish;
    rd_addr = idx_r[AW-1:0];
    busy    = (state_r == S_SCAN) || done_r;
    done    = done_r;
    hit     = hit_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      done_r  <= 1'b0;
      dvld_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            tag_r   <= tag;
            idx_r   <= '0;
            dvld_r  <= 1'b0;
            state_r <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (finish) begin
            done_r  <= 1'b1;
            hit_r   <= match;
            dvld_r  <= 1'b0;
            state_r <= S_IDLE;
          end else begin
            dvld_r  <= 1'b1;
            dlast_r <= (idx_r + CW'(1)) == tag_count;
            idx_r   <= idx_r + CW'(1);
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/prefix_boolean_membership_eval_top.sv
// add tag, and, or, not, finish, clear list and unused codes are handled when accepted
// operand: pushed when accepted if the list is empty or the stack is full, otherwise
//   a scan of the tag list (one tag list ram read per cycle, stops at first match)
// finish result is registered, ready on the cycle after the request is taken
// reset (rst_n low, synchronous) empties stack and list, clears their flags and out_valid
`default_nettype none

module prefix_boolean_membership_eval_top #(
  parameter int STACK_DEPTH = 32,
  parameter int LIST_DEPTH  = 64
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [pbme_pkg::REQ_W-1:0]    in_req_type,
  input  wire logic [pbme_pkg::TAG_W-1:0]    in_tag,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic                               out_verdict,
  output logic      [pbme_pkg::STATUS_W-1:0] out_status,
  output logic                               out_list_overflowed
);

  import pbme_pkg::*;

  localparam int AW  = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int TCW = $clog2(LIST_DEPTH + 1);

  // list bookkeeping
  logic [TCW-1:0]   tag_count_r, tag_count_nxt;
  logic             list_full_r, list_full_nxt;

  // result register
  logic             out_valid_r, out_valid_nxt;
  logic             out_verdict_r, out_verdict_nxt;
  status_t          out_status_r, out_status_nxt;
  logic             out_ovf_r, out_ovf_nxt;

  logic             acc;
  logic             list_has_room;
  logic             ram_we;
  logic             ram_re;
  logic [AW-1:0]    ram_raddr;
  logic [TAG_W-1:0] ram_rdata;
  logic             scan_start;
  logic             scan_busy;
  logic             scan_done;
  logic             scan_hit;
  stk_cmd_t         stk_cmd;
  stk_stat_t        stk_stat;

  // one request at a time; a waiting result only blocks when it can't drain
  assign in_ready      = !scan_busy && (!out_valid_r || out_ready);
  assign acc           = in_valid && in_ready;
  assign list_has_room = (tag_count_r < TCW'(LIST_DEPTH));

  always_comb begin
    tag_count_nxt   = tag_count_r;
    list_full_nxt   = list_full_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    out_verdict_nxt = out_verdict_r;
    out_status_nxt  = out_status_r;
    out_ovf_nxt     = out_ovf_r;
    ram_we          = 1'b0;
    scan_start      = 1'b0;
    stk_cmd.op      = SOP_NONE;
    stk_cmd.bit_val = 1'b0;

    // membership lookup finished, push its answer
    if (scan_done) begin
      stk_cmd.op      = SOP_PUSH;
      stk_cmd.bit_val = scan_hit;
    end

    if (acc) begin
      unique case (in_req_type)
        REQ_ADD: begin
          if (list_has_room) begin
            ram_we        = 1'b1;
            tag_count_nxt = tag_count_r + TCW'(1);
          end else begin
            list_full_nxt = 1'b1;
          end
        end
        REQ_OPERAND: begin
          // full stack records overflow in the stack, empty list is a miss
          if (stk_stat.full || tag_count_r == '0) begin
            stk_cmd.op = SOP_PUSH;
          end else begin
            scan_start = 1'b1;
          end
        end
        REQ_AND:    stk_cmd.op = SOP_AND;
        REQ_OR:     stk_cmd.op = SOP_OR;
        REQ_NOT:    stk_cmd.op = SOP_NOT;
        REQ_FINISH: begin
          stk_cmd.op      = SOP_FINISH;
          out_valid_nxt   = 1'b1;
          out_verdict_nxt = stk_stat.verdict;
          out_status_nxt  = stk_stat.status;
          out_ovf_nxt     = list_full_r;
        end
        REQ_CLEAR: begin
          tag_count_nxt = '0;
          list_full_nxt = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    out_verdict_r <= out_verdict_nxt;
    out_status_r  <= out_status_nxt;
    out_ovf_r     <= out_ovf_nxt;
    if (!rst_n) begin
      tag_count_r <= '0;
      list_full_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      tag_count_r <= tag_count_nxt;
      list_full_r <= list_full_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_verdict         = out_verdict_r;
  assign out_status          = out_status_r;
  assign out_list_overflowed = out_ovf_r;

  // tag list storage, written at the fill count, read by the scanner
  pbme_ram #(
    .WIDTH (TAG_W),
    .DEPTH (LIST_DEPTH),
    .AW    (AW)
  ) u_list (
    .clk   (clk),
    .we    (ram_we),
    .waddr (tag_count_r[AW-1:0]),
    .wdata (in_tag),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // sequencer walking the list with its tag comparator
  pbme_scan #(
    .LIST_DEPTH (LIST_DEPTH),
    .AW         (AW),
    .CW         (TCW)
  ) u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (scan_start),
    .tag       (in_tag),
    .tag_count (tag_count_r),
    .rd_en     (ram_re),
    .rd_addr   (ram_raddr),
    .rd_data   (ram_rdata),
    .busy      (scan_busy),
    .done      (scan_done),
    .hit       (scan_hit)
  );

  // operand bit stack with first-error tracking
  pbme_stack #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (stk_cmd),
    .stat  (stk_stat)
  );

endmodule

`default_nettype wire
